>>> src/lfsm_pkg.sv
`timescale 1ns / 1ps
package lfsm_pkg;

  // Front sensor patterns, bit2 bit1 bit0
  localparam logic [2:0] PAT_NONE        = 3'b000;
  localparam logic [2:0] PAT_RIGHT_FAR   = 3'b001;
  localparam logic [2:0] PAT_CENTER      = 3'b010;
  localparam logic [2:0] PAT_RIGHT_NEAR  = 3'b011;
  localparam logic [2:0] PAT_LEFT_FAR    = 3'b100;
  localparam logic [2:0] PAT_SPLIT       = 3'b101;
  localparam logic [2:0] PAT_LEFT_NEAR   = 3'b110;
  localparam logic [2:0] PAT_ALL         = 3'b111;

  // Configuration register indexes
  localparam logic [1:0] REG_FORWARD_SPEED     = 2'd0;
  localparam logic [1:0] REG_PROPORTIONAL_GAIN = 2'd1;
  localparam logic [1:0] REG_INTEGRAL_PERIOD   = 2'd2;

  localparam logic [7:0] RST_FORWARD_SPEED     = 8'd127;
  localparam logic [6:0] RST_PROPORTIONAL_GAIN = 7'd40;
  localparam logic [7:0] RST_INTEGRAL_PERIOD   = 8'd10;

  localparam logic [6:0] INTEGRAL_MAX = 7'd127;

  localparam int unsigned CMD_W = 8;
  localparam int unsigned ROT_W = 10;
  localparam int unsigned SUM_W = 11;

endpackage

>>> src/lfsm_mix.sv
`timescale 1ns / 1ps
// Mixes forward speed and rotation into clamped wheel codes.
module lfsm_mix (
  input  logic signed [7:0]                    speed_i,
  input  logic signed [lfsm_pkg::ROT_W-1:0]    rotation_i,
  output logic        [lfsm_pkg::CMD_W-1:0]    left_command_o,
  output logic        [lfsm_pkg::CMD_W-1:0]    right_command_o
);

  logic signed [lfsm_pkg::SUM_W-1:0] speed_ext;
  logic signed [lfsm_pkg::SUM_W-1:0] rot_ext;
  logic signed [lfsm_pkg::SUM_W-1:0] left_sum;
  logic signed [lfsm_pkg::SUM_W-1:0] right_sum;

  function automatic logic [lfsm_pkg::CMD_W-1:0] to_code(
    input logic signed [lfsm_pkg::SUM_W-1:0] v
  );
    logic signed [lfsm_pkg::SUM_W-1:0] r;
    begin
      r = '0;
      if (v > 11'sd127) begin
        r = 11'sd127;
      end else if (v < -11'sd127) begin
        r = 11'sd254;
      end else if (v < 11'sd0) begin
        r = 11'sd127 - v;
      end else begin
        r = v;
      end
      to_code = r[lfsm_pkg::CMD_W-1:0];
    end
  endfunction

  assign speed_ext = {{(lfsm_pkg::SUM_W-8){speed_i[7]}}, speed_i};
  assign rot_ext   = {{(lfsm_pkg::SUM_W-lfsm_pkg::ROT_W){rotation_i[lfsm_pkg::ROT_W-1]}},
                      rotation_i};
  assign left_sum  = rot_ext + speed_ext;
  assign right_sum = rot_ext - speed_ext;

  assign left_command_o  = to_code(left_sum);
  assign right_command_o = to_code(right_sum);

endmodule

>>> src/line_follow_steer_mixer_top.sv
`timescale 1ns / 1ps
// Line follower steering and wheel mixer.
// Input channel: in_valid_i / in_ready_o carry one request, a 3-bit front
// sensor sample (sensor_bits_i). Output channel: out_valid_o / out_ready_i
// carry one result per request: left and right motor codes, the rotation
// demand before mixing and a line lost flag.
// Config: cfg_we_i writes cfg_data_i to the register at cfg_index_i
// (0 forward speed, 1 gain, 2 integral period); other indexes are ignored.
// Write only while no request is in flight.
// Output path: an accepted request passes the sample register, then the
// result register, which drives out_valid_o.
// Throughput: one request per cycle while the receiver does not stall; the
// only loop is the tick counter / integral update, computed combinationally.
// Receiver stall: the result register holds, the sample register holds one
// more request behind it, then in_ready_o drops until out_ready_i returns.
// Reset: config registers take 127 / 40 / 10, tick count and integral clear,
// both channels go empty.
module line_follow_steer_mixer_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [7:0]                          cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [2:0]                          sensor_bits_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [lfsm_pkg::CMD_W-1:0]          left_command_o,
  output logic [lfsm_pkg::CMD_W-1:0]          right_command_o,
  output logic signed [lfsm_pkg::ROT_W-1:0]   rotation_demand_o,
  output logic                                line_lost_o
);

  // config
  logic [7:0] speed_q;
  logic [6:0] gain_q;
  logic [7:0] period_q;

  // loop state
  logic [7:0] tick_q, tick_d;
  logic [6:0] integ_q, integ_d;

  // sample stage
  logic       smp_valid_q;
  logic [2:0] smp_bits_q;

  // result stage
  logic                               res_valid_q;
  logic [lfsm_pkg::CMD_W-1:0]         left_q, right_q;
  logic signed [lfsm_pkg::ROT_W-1:0]  rot_q;
  logic                               lost_q;

  logic advance;
  logic clear_pat;
  logic [7:0] tick_inc;
  logic signed [lfsm_pkg::ROT_W-1:0] rot_d;
  logic signed [lfsm_pkg::ROT_W-1:0] p1, p2, integ_ext;
  logic [lfsm_pkg::CMD_W-1:0] left_d, right_d;

  assign advance    = smp_valid_q && (!res_valid_q || out_ready_i);
  assign in_ready_o = !smp_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_q  <= lfsm_pkg::RST_FORWARD_SPEED;
      gain_q   <= lfsm_pkg::RST_PROPORTIONAL_GAIN;
      period_q <= lfsm_pkg::RST_INTEGRAL_PERIOD;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lfsm_pkg::REG_FORWARD_SPEED:     speed_q  <= cfg_data_i;
        lfsm_pkg::REG_PROPORTIONAL_GAIN: gain_q   <= cfg_data_i[6:0];
        lfsm_pkg::REG_INTEGRAL_PERIOD:   period_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // centre and all-line clear the loop; anything else ticks
  assign clear_pat = (smp_bits_q == lfsm_pkg::PAT_CENTER) ||
                     (smp_bits_q == lfsm_pkg::PAT_ALL);
  assign tick_inc  = tick_q + 8'd1;

  always_comb begin
    tick_d  = tick_q;
    integ_d = integ_q;
    if (clear_pat) begin
      tick_d  = '0;
      integ_d = '0;
    end else if (tick_inc == period_q) begin
      tick_d = '0;
      if (integ_q != lfsm_pkg::INTEGRAL_MAX) begin
        integ_d = integ_q + 7'd1;
      end
    end else begin
      tick_d = tick_inc;
    end
  end

  assign p1        = {{(lfsm_pkg::ROT_W-7){1'b0}}, gain_q};
  assign p2        = {{(lfsm_pkg::ROT_W-8){1'b0}}, gain_q, 1'b0};
  assign integ_ext = {{(lfsm_pkg::ROT_W-7){1'b0}}, integ_d};

  // integral enters only for the four side patterns, always with a positive sign
  always_comb begin
    case (smp_bits_q)
      lfsm_pkg::PAT_RIGHT_NEAR: rot_d = integ_ext + p1;
      lfsm_pkg::PAT_RIGHT_FAR:  rot_d = integ_ext + p2;
      lfsm_pkg::PAT_LEFT_NEAR:  rot_d = integ_ext - p1;
      lfsm_pkg::PAT_LEFT_FAR:   rot_d = integ_ext - p2;
      default:                  rot_d = '0;
    endcase
  end

  lfsm_mix u_mix (
    .speed_i         (speed_q),
    .rotation_i      (rot_d),
    .left_command_o  (left_d),
    .right_command_o (right_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
      tick_q      <= '0;
      integ_q     <= '0;
    end else begin
      if (in_ready_o) begin
        smp_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= 1'b1;
        tick_q      <= tick_d;
        integ_q     <= integ_d;
      end else if (out_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      smp_bits_q <= sensor_bits_i;
    end
    if (advance) begin
      left_q  <= left_d;
      right_q <= right_d;
      rot_q   <= rot_d;
      lost_q  <= (smp_bits_q == lfsm_pkg::PAT_NONE);
    end
  end

  assign out_valid_o       = res_valid_q;
  assign left_command_o    = left_q;
  assign right_command_o   = right_q;
  assign rotation_demand_o = rot_q;
  assign line_lost_o       = lost_q;

  // centre or all-line leaves the loop state cleared
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && clear_pat |=> (tick_q == 8'd0) && (integ_q == 7'd0))
    else $error("loop state not cleared");

  // integral never decreases between clears
  a_integ_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && !clear_pat |=> integ_q >= $past(integ_q))
    else $error("integral decreased");

  // lost line carries no rotation
  a_lost_rot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_lost_o |-> rotation_demand_o == '0)
    else $error("rotation on lost line");

  // stalled result is not overwritten
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(rotation_demand_o))
    else $error("stalled result lost");

endmodule
